// ===== rtl/core/rdq_pkg.sv =====
`default_nettype none

package rdq_pkg;

  // Default for the top level parameter
  localparam int DEPTH_DEF = 16;

  // Fixed field widths of the request and response beats
  localparam int REQ_W   = 3;
  localparam int ITEM_W  = 8;
  localparam int COUNT_W = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SCAN       = 3'd5;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ITEM_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [ITEM_W-1:0]  front_value;
    logic [ITEM_W-1:0]  back_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic [ITEM_W-1:0]  max_value;
    logic [ITEM_W-1:0]  min_value;
    logic               extremes_valid;
    logic               req_error;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_OUT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic apply;      // request beat taken: update pointers, write entry
    logic scan_step;  // issue one scan read
    logic read_ends;  // read the head and tail entries
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_scan; // offered request is a scan over a non-empty queue
    logic scan_last;  // current scan read is the final entry
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/reversible_deque_with_extremes_top.sv =====
// Channel  Signals                      Beat
// req      req_valid, req_ready, req    one request: type and value to push
// rsp      rsp_valid, rsp_ready, rsp    one response: ends, count, extremes, error
//
// One request at a time. Push, pop, reverse and bad requests pass through
// apply, end read and response. A scan adds one read per held entry through
// the store's first read port, between apply and end read.
// rst is synchronous and clears pointers, count, reverse flag and control.
// The response stays registered until rsp_ready; req_ready is low meanwhile.
`default_nettype none

module reversible_deque_with_extremes_top #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_ready,
  input  rdq_pkg::req_t  req,
  output logic           rsp_valid,
  input  wire            rsp_ready,
  output rdq_pkg::rsp_t  rsp
);
  import rdq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

`ifndef SYNTHESIS
  // never take a request while a response is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while response pending");

  // a taken request blocks the next one in the cycle after it
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("back to back request accepted");

  // valid extremes are ordered
  a_extremes_order: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.extremes_valid) |-> (rsp.min_value <= rsp.max_value))
    else $error("scan minimum above maximum");

  // a valid scan is never an error
  a_extremes_no_err: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.extremes_valid) |-> !rsp.req_error)
    else $error("valid scan flagged as error");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rdq_ctrl.sv =====
`default_nettype none

module rdq_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  wire                    rsp_ready,
  input  rdq_pkg::dp_status_t    status,
  output rdq_pkg::ctrl_cmd_t     cmd
);
  import rdq_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = status.start_scan ? ST_SCAN : ST_READ;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_ready     = 1'b0;
    rsp_valid     = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.apply = req_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_READ: begin
        cmd.read_ends = 1'b1;
      end
      ST_OUT: begin
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/rdq_dpath.sv =====
`default_nettype none

module rdq_dpath #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  rdq_pkg::req_t        req,
  input  rdq_pkg::ctrl_cmd_t   cmd,
  output rdq_pkg::dp_status_t  status,
  output rdq_pkg::rsp_t        rsp
);
  import rdq_pkg::*;

  localparam int DATA_WIDTH = ITEM_W;
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [IW:0]   DEPTH_C   = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_C    = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [IW-1:0]         head;
  logic [CW-1:0]         occ;
  logic                  rev;
  logic                  err;
  logic                  ext_valid;
  logic [DATA_WIDTH-1:0] max_r;
  logic [DATA_WIDTH-1:0] min_r;
  logic [IW-1:0]         scan_ptr;
  logic [IW-1:0]         scan_cnt;
  logic                  scan_pend;
  logic                  scan_first;
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;

  logic                  is_push;
  logic                  is_pop;
  logic                  full;
  logic                  empty;
  logic                  push_ok;
  logic                  pop_ok;
  logic                  push_head;
  logic                  pop_at_head;
  logic                  bad_req;
  logic [IW-1:0]         head_dec;
  logic [IW-1:0]         head_inc;
  logic [IW-1:0]         ptr_inc;
  logic [IW-1:0]         tail_off;
  logic [IW:0]           tail_sum;
  logic [IW-1:0]         tail_slot;
  logic [IW-1:0]         wr_addr;
  logic [IW-1:0]         rd_addr_a;
  logic [DATA_WIDTH-1:0] front_d;
  logic [DATA_WIDTH-1:0] back_d;

  // Request decode
  always_comb begin
    is_push     = req.req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK};
    is_pop      = req.req_type inside {REQ_POP_FRONT, REQ_POP_BACK};
    bad_req     = !(req.req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_POP_FRONT,
                                         REQ_POP_BACK, REQ_REVERSE, REQ_SCAN});
    full        = (occ == FULL_C);
    empty       = (occ == '0);
    push_ok     = is_push && !full;
    pop_ok      = is_pop && !empty;
    push_head   = (req.req_type == REQ_PUSH_FRONT) != rev;
    pop_at_head = (req.req_type == REQ_POP_FRONT) != rev;
  end

  // Ring index arithmetic
  always_comb begin
    head_dec  = (head == '0) ? LAST_SLOT : head - 1'b1;
    head_inc  = (head == LAST_SLOT) ? '0 : head + 1'b1;
    ptr_inc   = (scan_ptr == LAST_SLOT) ? '0 : scan_ptr + 1'b1;
    // tail write slot while idle, last live slot while reading ends
    tail_off  = cmd.read_ends ? IW'(occ - 1'b1) : IW'(occ);
    tail_sum  = {1'b0, head} + {1'b0, tail_off};
    tail_slot = (tail_sum >= DEPTH_C) ? IW'(tail_sum - DEPTH_C) : tail_sum[IW-1:0];
    wr_addr   = push_head ? head_dec : tail_slot;
    rd_addr_a = cmd.read_ends ? head : scan_ptr;
  end

  // Status to the controller
  always_comb begin
    status.start_scan = (req.req_type == REQ_SCAN) && !empty;
    status.scan_last  = (CW'(scan_cnt) == occ - 1'b1);
  end

  // Queue pointers and reverse flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
      rev  <= 1'b0;
    end else if (cmd.apply) begin
      if (push_ok) begin
        occ <= occ + 1'b1;
        if (push_head) begin
          head <= head_dec;
        end
      end else if (pop_ok) begin
        occ <= occ - 1'b1;
        if (pop_at_head) begin
          head <= head_inc;
        end
      end else if (req.req_type == REQ_REVERSE) begin
        rev <= !rev;
      end
    end
  end

  // Error flag of the current request
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      err <= bad_req || (is_push && full) || (is_pop && empty)
             || ((req.req_type == REQ_SCAN) && empty);
    end
  end

  // Entry store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.apply && push_ok) begin
      mem[wr_addr] <= DATA_WIDTH'(req.item_value);
    end
    if (cmd.read_ends || cmd.scan_step) begin
      rd_a <= mem[rd_addr_a];
    end
    if (cmd.read_ends) begin
      rd_b <= mem[tail_slot];
    end
  end

  // Scan address walk
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pend <= 1'b0;
    end else begin
      scan_pend <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      scan_ptr <= head;
      scan_cnt <= '0;
    end else if (cmd.scan_step) begin
      scan_ptr <= ptr_inc;
      scan_cnt <= scan_cnt + 1'b1;
    end
  end

  // Running extremes, one entry per cycle behind the read
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      max_r      <= '0;
      min_r      <= '0;
      scan_first <= 1'b1;
      ext_valid  <= status.start_scan;
    end else if (scan_pend) begin
      scan_first <= 1'b0;
      if (scan_first || (rd_a > max_r)) begin
        max_r <= rd_a;
      end
      if (scan_first || (rd_a < min_r)) begin
        min_r <= rd_a;
      end
    end
  end

  // Response beat, held stable while waiting
  always_comb begin
    front_d = empty ? '0 : (rev ? rd_b : rd_a);
    back_d  = empty ? '0 : (rev ? rd_a : rd_b);
    rsp.front_value    = ITEM_W'(front_d);
    rsp.back_value     = ITEM_W'(back_d);
    rsp.entry_count    = COUNT_W'(occ);
    rsp.is_empty       = empty;
    rsp.max_value      = ITEM_W'(max_r);
    rsp.min_value      = ITEM_W'(min_r);
    rsp.extremes_valid = ext_valid;
    rsp.req_error      = err;
  end

endmodule

`default_nettype wire

// ===== tb/deque_response_checker.sv =====
`timescale 1ns / 100ps

module deque_response_checker
  import rdq_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  input  wire  req_ready,
  input  req_t req,
  input  wire  rsp_valid,
  input  wire  rsp_ready,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending,
  output int   rsp_count,
  output int   err_count,
  output int   full_refusals,
  output int   scan_count
);

  localparam int DEPTH     = DEPTH_DEF;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int PRINT_CAP = 100;

  // Shadow copy of the deque
  logic [ITEM_W-1:0]  slots [DEPTH];
  logic [IDX_W-1:0]   head_ptr;
  logic [COUNT_W-1:0] fill;
  logic               flipped;

  // Responses still owed by the block, oldest first
  rsp_t awaited_rsp [$];

  // One line per mismatch, quiet after the first hundred
  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Apply one request to the shadow deque and build the response it owes
  function automatic rsp_t deque_response(input req_t r);
    rsp_t               e;
    logic [ITEM_W-1:0]  v;
    logic [ITEM_W-1:0]  head_val;
    logic [ITEM_W-1:0]  tail_val;
    e = '0;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill == DEPTH) begin
          e.req_error = 1'b1;
          full_refusals++;
        end else if ((r.req_type == REQ_PUSH_FRONT) != flipped) begin
          head_ptr = head_ptr - 1'b1;
          slots[head_ptr] = r.item_value;
          fill++;
        end else begin
          slots[IDX_W'(head_ptr + fill)] = r.item_value;
          fill++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (fill == 0) begin
          e.req_error = 1'b1;
        end else if ((r.req_type == REQ_POP_FRONT) != flipped) begin
          head_ptr = head_ptr + 1'b1;
          fill--;
        end else begin
          fill--;
        end
      end
      REQ_REVERSE: begin
        flipped = !flipped;
      end
      REQ_SCAN: begin
        if (fill == 0) begin
          e.req_error = 1'b1;
        end else begin
          e.max_value = slots[head_ptr];
          e.min_value = slots[head_ptr];
          for (int i = 1; i < fill; i++) begin
            v = slots[IDX_W'(head_ptr + i)];
            if (v > e.max_value) e.max_value = v;
            if (v < e.min_value) e.min_value = v;
          end
          e.extremes_valid = 1'b1;
          scan_count++;
        end
      end
      default: begin
        e.req_error = 1'b1;
      end
    endcase

    // Ends as seen through the reverse flag
    head_val = '0;
    tail_val = '0;
    if (fill != 0) begin
      head_val = slots[head_ptr];
      tail_val = slots[IDX_W'(head_ptr + fill - 1)];
    end
    e.front_value = flipped ? tail_val : head_val;
    e.back_value  = flipped ? head_val : tail_val;
    e.entry_count = fill;
    e.is_empty    = (fill == 0);
    if (e.req_error) err_count++;
    return e;
  endfunction

  task automatic compare_rsp(input rsp_t got, input rsp_t want);
    string tag;
    tag = $sformatf("response %0d", rsp_count);
    if (got.front_value !== want.front_value)
      report_mismatch($sformatf("%s front_value %0d, expected %0d",
                                tag, got.front_value, want.front_value));
    if (got.back_value !== want.back_value)
      report_mismatch($sformatf("%s back_value %0d, expected %0d",
                                tag, got.back_value, want.back_value));
    if (got.entry_count !== want.entry_count)
      report_mismatch($sformatf("%s entry_count %0d, expected %0d",
                                tag, got.entry_count, want.entry_count));
    if (got.is_empty !== want.is_empty)
      report_mismatch($sformatf("%s is_empty %0b, expected %0b",
                                tag, got.is_empty, want.is_empty));
    if (got.max_value !== want.max_value)
      report_mismatch($sformatf("%s max_value %0d, expected %0d",
                                tag, got.max_value, want.max_value));
    if (got.min_value !== want.min_value)
      report_mismatch($sformatf("%s min_value %0d, expected %0d",
                                tag, got.min_value, want.min_value));
    if (got.extremes_valid !== want.extremes_valid)
      report_mismatch($sformatf("%s extremes_valid %0b, expected %0b",
                                tag, got.extremes_valid, want.extremes_valid));
    if (got.req_error !== want.req_error)
      report_mismatch($sformatf("%s req_error %0b, expected %0b",
                                tag, got.req_error, want.req_error));
  endtask

  // Watch both channels: score the response beat, then predict the request beat
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) slots[i] = '0;
      head_ptr = '0;
      fill     = '0;
      flipped  = 1'b0;
      awaited_rsp.delete();
      fail_count    = 0;
      rsp_count     = 0;
      err_count     = 0;
      full_refusals = 0;
      scan_count    = 0;
      pending <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_count++;
        if (awaited_rsp.size() == 0) begin
          report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                    rsp_count));
        end else begin
          compare_rsp(rsp, awaited_rsp[0]);
          awaited_rsp.delete(0);
        end
      end
      if (req_valid && req_ready) begin
        awaited_rsp.insert(awaited_rsp.size(), deque_response(req));
      end
      pending <= awaited_rsp.size();
    end
  end

endmodule

// ===== tb/tb_reversible_deque_with_extremes_top.sv =====
`timescale 1ns / 100ps

module tb_reversible_deque_with_extremes_top;
  import rdq_pkg::*;

  // Request codes the block does not define
  localparam logic [REQ_W-1:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS   = 150;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_SCAN} traffic_mix_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic send_gaps  = 1'b1;
  logic rsp_stalls = 1'b1;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   sent = 0;
  int   directed = 0;

  int fail_count, pending, rsp_count, err_count, full_refusals, scan_count;

  reversible_deque_with_extremes_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  deque_response_checker chk (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending       (pending),
    .rsp_count     (rsp_count),
    .err_count     (err_count),
    .full_refusals (full_refusals),
    .scan_count    (scan_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response side: after each beat, hold ready low for a randomly drawn stall
  always @(posedge clk) begin : rsp_side
    int hold;
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
    end else if (rsp_valid && rsp_ready) begin
      hold = rsp_stalls ? $urandom_range(0, 15) : 0;
      stall_left <= hold;
      rsp_ready  <= (hold == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      rsp_ready  <= 1'b1;
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles with no beat", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic req_t beat_of(input logic [REQ_W-1:0] kind,
                                   input logic [ITEM_W-1:0] value);
    req_t r;
    r.req_type   = kind;
    r.item_value = value;
    return r;
  endfunction

  // Random request, weighted by the traffic mix of the phase
  function automatic req_t pick_req(input traffic_mix_t mix);
    req_t r;
    int   roll;
    int   pick;
    int   push_cut, pop_cut, rev_cut, scan_cut;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        push_cut = 70; pop_cut = 85; rev_cut = 91; scan_cut = 98;
      end
      MIX_DRAIN: begin
        push_cut = 20; pop_cut = 75; rev_cut = 84; scan_cut = 97;
      end
      MIX_EVEN: begin
        push_cut = 42; pop_cut = 82; rev_cut = 90; scan_cut = 98;
      end
      default: begin
        push_cut = 35; pop_cut = 60; rev_cut = 75; scan_cut = 97;
      end
    endcase
    // Bias values toward the unsigned extremes
    pick = $urandom_range(0, 9);
    if (pick == 0) r.item_value = '0;
    else if (pick == 1) r.item_value = '1;
    else r.item_value = ITEM_W'($urandom_range(0, 255));
    if (roll < push_cut)
      r.req_type = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    else if (roll < pop_cut)
      r.req_type = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
    else if (roll < rev_cut)
      r.req_type = REQ_REVERSE;
    else if (roll < scan_cut)
      r.req_type = REQ_SCAN;
    else
      r.req_type = $urandom_range(0, 1) ? REQ_UNDEF_HI : REQ_UNDEF_LO;
    return r;
  endfunction

  // Offer one request beat after an optional gap, return once it is taken
  task automatic send_req(input req_t r);
    int gap;
    gap = send_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    sent++;
  endtask

  // Hold off the request side until every response is back
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-queue corner cases, both push ends, reverse, scans, bad codes
    send_req(beat_of(REQ_PUSH_FRONT, 8'h00));
    send_req(beat_of(REQ_POP_BACK,   8'hFF));
    send_req(beat_of(REQ_POP_FRONT,  8'h00));
    send_req(beat_of(REQ_POP_BACK,   8'h00));
    send_req(beat_of(REQ_SCAN,       8'hFF));
    send_req(beat_of(REQ_PUSH_BACK,  8'hFF));
    send_req(beat_of(REQ_PUSH_FRONT, 8'h80));
    send_req(beat_of(REQ_PUSH_BACK,  8'h00));
    send_req(beat_of(REQ_SCAN,       8'h00));
    send_req(beat_of(REQ_REVERSE,    8'h00));
    send_req(beat_of(REQ_PUSH_FRONT, 8'h01));
    send_req(beat_of(REQ_PUSH_BACK,  8'hFE));
    send_req(beat_of(REQ_SCAN,       8'h00));
    send_req(beat_of(REQ_POP_BACK,   8'h00));
    send_req(beat_of(REQ_REVERSE,    8'hFF));
    send_req(beat_of(REQ_POP_FRONT,  8'h00));
    send_req(beat_of(REQ_UNDEF_LO,   8'hAA));
    send_req(beat_of(REQ_UNDEF_HI,   8'h55));
    send_req(beat_of(REQ_POP_FRONT,  8'h00));
    send_req(beat_of(REQ_POP_BACK,   8'h00));
    send_req(beat_of(REQ_POP_FRONT,  8'h00));
    send_req(beat_of(REQ_SCAN,       8'h00));
    directed = sent;

    // Random phases: fill, drain, even and scan-heavy traffic, idling varied
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      send_gaps  = (p % 3) != 0;
      rsp_stalls <= (p % 4) != 1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_req(pick_req(traffic_mix_t'(p % 4)));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed), checked %0d responses, %0d flagged as errors.",
             sent, directed, rsp_count, err_count);
    $display("Pushes refused on a full deque: %0d; extremes scans over held entries: %0d.",
             full_refusals, scan_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d responses never arrived", fail_count, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
